// File: rtl/va_pkg.sv
// shared types, constants and helpers for the 2-d vector arithmetic unit
`default_nettype none

package va_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 4;
  localparam int EPS_W       = 16;
  localparam int IN_W        = 4 * DATA_W;
  localparam int OUT_W       = 3 * DATA_W;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int WIDE_W      = PROD_W + 2;
  localparam int NUM_W       = DATA_W + FRAC_BITS;
  localparam int ROOT_W      = DATA_W;
  localparam int REM_W       = ROOT_W + 3;
  localparam int SQRT_STEPS  = 4;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = NUM_W / DIV_STEPS;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t VMIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_MUL       = 4'd2,
    OP_DIV       = 4'd3,
    OP_SCALE     = 4'd4,
    OP_SCALE_DIV = 4'd5,
    OP_NORMALIZE = 4'd6,
    OP_DOT       = 4'd7,
    OP_LENGTH    = 4'd8,
    OP_EQUAL     = 4'd9,
    OP_IS_ZERO   = 4'd10
  } op_t;

  // one divider lane: magnitude dividend (quotient once divided) and sign info
  typedef struct packed {
    logic              neg_q;
    logic              a_neg;
    logic              a_zero;
    logic              d_zero;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] den;
  } lane_t;

  typedef struct packed {
    op_t               op;
    word_t             rx;
    word_t             ry;
    word_t             sc;
    logic              flag;
    logic              err;
    logic [ROOT_W-1:0] len;
    lane_t             lx;
    lane_t             ly;
  } item_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_t;

  function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] v);
    sat_t s;
    if (v[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){v[WIDE_W-1]}}) begin
      s.val = v[WIDE_W-1] ? VMIN : VMAX;
      s.ovf = 1'b1;
    end else begin
      s.val = v[DATA_W-1:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] mag(input word_t v);
    logic [DATA_W-1:0] m;
    m = v[DATA_W-1] ? (~v + 1'b1) : v;
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/va_front.sv
// front end: decode, products, add/sub/compare, rounding of products
`default_nettype none

module va_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  va_pkg::op_t                 op,
  input  va_pkg::word_t               ax,
  input  va_pkg::word_t               ay,
  input  va_pkg::word_t               bx,
  input  va_pkg::word_t               by,
  input  logic [va_pkg::EPS_W-1:0]    eps,
  output logic                        out_valid,
  input  logic                        out_ready,
  output va_pkg::item_t               out_item,
  output logic [va_pkg::PROD_W-1:0]   out_ssq
);
  import va_pkg::*;

  localparam logic signed [WIDE_W-1:0] HALF =
    {{(WIDE_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic s1_valid_r, s2_valid_r;
  logic s1_rdy, s2_rdy;
  item_t s1_item_r, s1_item_nxt, s2_item_r, s2_item_nxt;
  logic signed [PROD_W-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic [PROD_W-1:0] ssq_r, ssq_nxt;

  word_t m1, m2, by_eff;
  logic signed [DATA_W:0] sum_x, sum_y, dif_x, dif_y, ex, ey, adx, ady;
  sat_t sat_x, sat_y;
  logic eq_x, eq_y, len_op;

  logic signed [WIDE_W-1:0] w1, w2, wd, r1, r2, rd;
  sat_t sm1, sm2, sdot;

  // stage 1
  always_comb begin
    len_op = (op == OP_NORMALIZE) || (op == OP_LENGTH);
    m1 = len_op ? ax : bx;
    m2 = len_op ? ay : ((op == OP_SCALE) ? bx : by);
    p1_nxt = $signed({{DATA_W{ax[DATA_W-1]}}, ax}) * $signed({{DATA_W{m1[DATA_W-1]}}, m1});
    p2_nxt = $signed({{DATA_W{ay[DATA_W-1]}}, ay}) * $signed({{DATA_W{m2[DATA_W-1]}}, m2});

    sum_x = {ax[DATA_W-1], ax} + {bx[DATA_W-1], bx};
    sum_y = {ay[DATA_W-1], ay} + {by[DATA_W-1], by};
    dif_x = {ax[DATA_W-1], ax} - {bx[DATA_W-1], bx};
    dif_y = {ay[DATA_W-1], ay} - {by[DATA_W-1], by};
    ex = (op == OP_SUB) ? dif_x : sum_x;
    ey = (op == OP_SUB) ? dif_y : sum_y;
    sat_x = sat_wide({{(WIDE_W-DATA_W-1){ex[DATA_W]}}, ex});
    sat_y = sat_wide({{(WIDE_W-DATA_W-1){ey[DATA_W]}}, ey});

    adx = dif_x[DATA_W] ? -dif_x : dif_x;
    ady = dif_y[DATA_W] ? -dif_y : dif_y;
    eq_x = $unsigned(adx) <= {{(DATA_W+1-EPS_W){1'b0}}, eps};
    eq_y = $unsigned(ady) <= {{(DATA_W+1-EPS_W){1'b0}}, eps};

    by_eff = (op == OP_SCALE_DIV) ? bx : by;

    s1_item_nxt = '0;
    s1_item_nxt.op = op;
    s1_item_nxt.lx.num    = {mag(ax), {FRAC_BITS{1'b0}}};
    s1_item_nxt.lx.a_neg  = ax[DATA_W-1];
    s1_item_nxt.lx.a_zero = (ax == '0);
    s1_item_nxt.lx.den    = mag(bx);
    s1_item_nxt.lx.d_zero = (bx == '0);
    s1_item_nxt.lx.neg_q  = ax[DATA_W-1] ^ bx[DATA_W-1];
    s1_item_nxt.ly.num    = {mag(ay), {FRAC_BITS{1'b0}}};
    s1_item_nxt.ly.a_neg  = ay[DATA_W-1];
    s1_item_nxt.ly.a_zero = (ay == '0);
    s1_item_nxt.ly.den    = mag(by_eff);
    s1_item_nxt.ly.d_zero = (by_eff == '0);
    s1_item_nxt.ly.neg_q  = ay[DATA_W-1] ^ by_eff[DATA_W-1];
    if (op == OP_NORMALIZE) begin
      s1_item_nxt.lx.neg_q = ax[DATA_W-1];
      s1_item_nxt.ly.neg_q = ay[DATA_W-1];
    end

    case (op)
      OP_ADD, OP_SUB: begin
        s1_item_nxt.rx  = sat_x.val;
        s1_item_nxt.ry  = sat_y.val;
        s1_item_nxt.err = sat_x.ovf | sat_y.ovf;
      end
      OP_EQUAL:   s1_item_nxt.flag = eq_x & eq_y;
      OP_IS_ZERO: s1_item_nxt.flag = (ax == '0) && (ay == '0);
      OP_MUL, OP_DIV, OP_SCALE, OP_SCALE_DIV, OP_NORMALIZE, OP_DOT, OP_LENGTH: ;
      default:    s1_item_nxt.err = 1'b1;
    endcase
  end

  // stage 2: round half up by the fraction width
  always_comb begin
    w1 = {{2{p1_r[PROD_W-1]}}, p1_r} + HALF;
    w2 = {{2{p2_r[PROD_W-1]}}, p2_r} + HALF;
    wd = {{2{p1_r[PROD_W-1]}}, p1_r} + {{2{p2_r[PROD_W-1]}}, p2_r} + HALF;
    r1 = w1 >>> FRAC_BITS;
    r2 = w2 >>> FRAC_BITS;
    rd = wd >>> FRAC_BITS;
    sm1  = sat_wide(r1);
    sm2  = sat_wide(r2);
    sdot = sat_wide(rd);
    ssq_nxt = $unsigned(p1_r) + $unsigned(p2_r);

    s2_item_nxt = s1_item_r;
    case (s1_item_r.op)
      OP_MUL, OP_SCALE: begin
        s2_item_nxt.rx  = sm1.val;
        s2_item_nxt.ry  = sm2.val;
        s2_item_nxt.err = sm1.ovf | sm2.ovf;
      end
      OP_DOT: begin
        s2_item_nxt.sc  = sdot.val;
        s2_item_nxt.err = sdot.ovf;
      end
      default: ;
    endcase
  end

  assign s2_rdy   = !s2_valid_r || out_ready;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid_r <= in_valid;
      if (s2_rdy) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_item_r <= s1_item_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
    end
    if (s2_rdy && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
      ssq_r     <= ssq_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_item  = s2_item_r;
  assign out_ssq   = ssq_r;

endmodule

`default_nettype wire

// File: rtl/va_sqrt.sv
// pipelined integer square root of the sum of squares, rounded to nearest
`default_nettype none

module va_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  va_pkg::item_t             in_item,
  input  logic [va_pkg::PROD_W-1:0] in_ssq,
  output logic                      out_valid,
  input  logic                      out_ready,
  output va_pkg::item_t             out_item
);
  import va_pkg::*;

  localparam int NS = SQRT_STAGES;

  logic [NS:0]   vld_r;
  logic [NS:0]   vsrc;
  logic [NS+1:0] rdy;

  item_t             item_r   [NS+1];
  item_t             item_nxt [NS+1];
  logic [PROD_W-1:0] rad_r    [NS];
  logic [PROD_W-1:0] rad_nxt  [NS];
  logic [REM_W-1:0]  rem_r    [NS];
  logic [REM_W-1:0]  rem_nxt  [NS];
  logic [ROOT_W-1:0] root_r   [NS];
  logic [ROOT_W-1:0] root_nxt [NS];

  logic [PROD_W-1:0] rad_c;
  logic [REM_W-1:0]  rem_c;
  logic [ROOT_W-1:0] root_c;
  logic [ROOT_W-1:0] len_c;

  assign vsrc = {vld_r[NS-1:0], in_valid};

  always_comb begin
    rdy[NS+1] = out_ready;
    for (int s = NS; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  // one root bit per step, four steps per stage, then the rounding stage
  always_comb begin
    rad_c  = '0;
    rem_c  = '0;
    root_c = '0;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rad_c       = in_ssq;
        rem_c       = '0;
        root_c      = '0;
        item_nxt[s] = in_item;
      end else begin
        rad_c       = rad_r[s-1];
        rem_c       = rem_r[s-1];
        root_c      = root_r[s-1];
        item_nxt[s] = item_r[s-1];
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
        rem_c = {rem_c[REM_W-3:0], rad_c[PROD_W-1:PROD_W-2]};
        rad_c = {rad_c[PROD_W-3:0], 2'b00};
        if (rem_c >= {1'b0, root_c, 2'b01}) begin
          rem_c  = rem_c - {1'b0, root_c, 2'b01};
          root_c = {root_c[ROOT_W-2:0], 1'b1};
        end else begin
          root_c = {root_c[ROOT_W-2:0], 1'b0};
        end
      end
      rad_nxt[s]  = rad_c;
      rem_nxt[s]  = rem_c;
      root_nxt[s] = root_c;
    end

    len_c = (rem_r[NS-1] > {{(REM_W-ROOT_W){1'b0}}, root_r[NS-1]}) ?
            root_r[NS-1] + 1'b1 : root_r[NS-1];
    item_nxt[NS]     = item_r[NS-1];
    item_nxt[NS].len = len_c;
    if (item_r[NS-1].op == OP_NORMALIZE) begin
      item_nxt[NS].lx.den    = len_c;
      item_nxt[NS].ly.den    = len_c;
      item_nxt[NS].lx.d_zero = (len_c == '0);
      item_nxt[NS].ly.d_zero = (len_c == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s <= NS; s++) begin
        if (rdy[s]) vld_r[s] <= vsrc[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= NS; s++) begin
      if (rdy[s] && vsrc[s]) item_r[s] <= item_nxt[s];
    end
    for (int s = 0; s < NS; s++) begin
      if (rdy[s] && vsrc[s]) begin
        rad_r[s]  <= rad_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS];
  assign out_item  = item_r[NS];

endmodule

`default_nettype wire

// File: rtl/va_div.sv
// pipelined restoring divider, two lanes, quotient replaces the dividend
`default_nettype none

module va_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  va_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output va_pkg::item_t out_item
);
  import va_pkg::*;

  localparam int ND = DIV_STAGES;

  typedef struct packed {
    logic [DATA_W:0]  rem;
    logic [NUM_W-1:0] num;
  } dstep_t;

  function automatic dstep_t div_steps(input logic [DATA_W:0] rem_i,
                                       input logic [NUM_W-1:0] num_i,
                                       input logic [DATA_W-1:0] den);
    dstep_t d;
    logic [DATA_W:0] trial;
    d.rem = rem_i;
    d.num = num_i;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {d.rem[DATA_W-1:0], d.num[NUM_W-1]};
      d.num = {d.num[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        d.rem    = trial - {1'b0, den};
        d.num[0] = 1'b1;
      end else begin
        d.rem = trial;
      end
    end
    return d;
  endfunction

  logic [ND-1:0] vld_r;
  logic [ND-1:0] vsrc;
  logic [ND:0]   rdy;

  item_t           item_r   [ND];
  item_t           item_nxt [ND];
  logic [DATA_W:0] remx_r   [ND];
  logic [DATA_W:0] remy_r   [ND];
  logic [DATA_W:0] remx_nxt [ND];
  logic [DATA_W:0] remy_nxt [ND];

  item_t           src_c;
  logic [DATA_W:0] srx_c, sry_c;
  dstep_t          dx_c, dy_c;

  assign vsrc = {vld_r[ND-2:0], in_valid};

  always_comb begin
    rdy[ND] = out_ready;
    for (int s = ND - 1; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    src_c = in_item;
    srx_c = '0;
    sry_c = '0;
    dx_c  = '0;
    dy_c  = '0;
    for (int s = 0; s < ND; s++) begin
      if (s == 0) begin
        src_c = in_item;
        srx_c = '0;
        sry_c = '0;
      end else begin
        src_c = item_r[s-1];
        srx_c = remx_r[s-1];
        sry_c = remy_r[s-1];
      end
      dx_c = div_steps(srx_c, src_c.lx.num, src_c.lx.den);
      dy_c = div_steps(sry_c, src_c.ly.num, src_c.ly.den);
      item_nxt[s]        = src_c;
      item_nxt[s].lx.num = dx_c.num;
      item_nxt[s].ly.num = dy_c.num;
      remx_nxt[s]        = dx_c.rem;
      remy_nxt[s]        = dy_c.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < ND; s++) begin
        if (rdy[s]) vld_r[s] <= vsrc[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ND; s++) begin
      if (rdy[s] && vsrc[s]) begin
        item_r[s] <= item_nxt[s];
        remx_r[s] <= remx_nxt[s];
        remy_r[s] <= remy_nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[ND-1];
  assign out_item  = item_r[ND-1];

endmodule

`default_nettype wire

// File: rtl/va_back.sv
// result stage: quotient signs, saturation, length select, output register
`default_nettype none

module va_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  va_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output va_pkg::word_t rx,
  output va_pkg::word_t ry,
  output va_pkg::word_t sc,
  output logic          flag,
  output logic          err
);
  import va_pkg::*;

  localparam logic [NUM_W-1:0] MAG_NEG =
    {{(NUM_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [NUM_W-1:0] MAG_POS =
    {{(NUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};

  function automatic sat_t lane_res(input lane_t l);
    sat_t s;
    if (l.d_zero) begin
      s.ovf = 1'b1;
      s.val = l.a_zero ? '0 : (l.a_neg ? VMIN : VMAX);
    end else if (l.neg_q) begin
      if (l.num > MAG_NEG) begin
        s.ovf = 1'b1;
        s.val = VMIN;
      end else begin
        s.ovf = 1'b0;
        s.val = ~l.num[DATA_W-1:0] + 1'b1;
      end
    end else if (l.num > MAG_POS) begin
      s.ovf = 1'b1;
      s.val = VMAX;
    end else begin
      s.ovf = 1'b0;
      s.val = l.num[DATA_W-1:0];
    end
    return s;
  endfunction

  logic  out_valid_r, rdy;
  op_t   op_r;
  word_t rx_r, ry_r, sc_r, rx_nxt, ry_nxt, sc_nxt;
  logic  flag_r, err_r, flag_nxt, err_nxt;
  sat_t  res_x, res_y;

  always_comb begin
    res_x    = lane_res(in_item.lx);
    res_y    = lane_res(in_item.ly);
    rx_nxt   = in_item.rx;
    ry_nxt   = in_item.ry;
    sc_nxt   = in_item.sc;
    flag_nxt = in_item.flag;
    err_nxt  = in_item.err;
    case (in_item.op)
      OP_DIV, OP_SCALE_DIV: begin
        rx_nxt  = res_x.val;
        ry_nxt  = res_y.val;
        err_nxt = res_x.ovf | res_y.ovf;
      end
      OP_NORMALIZE: begin
        // a zero vector stays zero
        if (in_item.len != '0) begin
          rx_nxt  = res_x.val;
          ry_nxt  = res_y.val;
          err_nxt = res_x.ovf | res_y.ovf;
        end
      end
      OP_LENGTH: begin
        if (in_item.len[ROOT_W-1]) begin
          sc_nxt  = VMAX;
          err_nxt = 1'b1;
        end else begin
          sc_nxt = in_item.len;
        end
      end
      default: ;
    endcase
  end

  assign rdy      = !out_valid_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      op_r   <= in_item.op;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      sc_r   <= sc_nxt;
      flag_r <= flag_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign rx        = rx_r;
  assign ry        = ry_r;
  assign sc        = sc_r;
  assign flag      = flag_r;
  assign err       = err_r;

  a_flag_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && flag_r |-> (op_r == OP_EQUAL) || (op_r == OP_IS_ZERO))
    else $error("flag set on a non-test transaction");

  a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((op_r == OP_DOT) || (op_r == OP_LENGTH) ||
                    (op_r == OP_EQUAL) || (op_r == OP_IS_ZERO))
    |-> (rx_r == '0) && (ry_r == '0))
    else $error("vector result on a scalar transaction");

  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (op_r == OP_LENGTH) |-> !sc_r[DATA_W-1])
    else $error("negative length");

endmodule

`default_nettype wire

// File: rtl/vector2_arithmetic_unit.sv
// top level of the 2-d vector arithmetic unit
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   tdata ax,ay,bx,by; tuser op code
//   out_     out  out_tvalid/out_tready tdata rx,ry,scalar; tuser flag,error
//   cfg_     in   cfg_wr_en             cfg_wr_data eps
//
// one transaction per cycle sustained while out_tready is high; the stages from input to output:
// 2 product/rounding stages, 9 square root stages (4 root bits each plus
// rounding), 12 divider stages (4 quotient bits each), 1 output register
// every stage holds when its successor is full and stalled; empty stages fill up
// synchronous reset clears the valid bits and eps
`default_nettype none

module vector2_arithmetic_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [va_pkg::EPS_W-1:0]   cfg_wr_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [va_pkg::IN_W-1:0]    in_tdata,   // ax, ay, bx, by
  input  logic [va_pkg::OP_W-1:0]    in_tuser,   // req_type
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [va_pkg::OUT_W-1:0]   out_tdata,  // rx, ry, scalar_out
  output logic [1:0]                 out_tuser   // flag, error
);
  import va_pkg::*;

  logic [EPS_W-1:0] eps_r;

  logic  f_valid, f_ready, q_valid, q_ready, d_valid, d_ready;
  item_t f_item, q_item, d_item;
  logic [PROD_W-1:0] f_ssq;
  word_t rx, ry, sc;
  logic  flag, err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  va_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .op        (op_t'(in_tuser)),
    .ax        (in_tdata[DATA_W-1:0]),
    .ay        (in_tdata[2*DATA_W-1:DATA_W]),
    .bx        (in_tdata[3*DATA_W-1:2*DATA_W]),
    .by        (in_tdata[4*DATA_W-1:3*DATA_W]),
    .eps       (eps_r),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item),
    .out_ssq   (f_ssq)
  );

  va_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .in_ssq    (f_ssq),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  va_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_item  (d_item)
  );

  va_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_item   (d_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .rx        (rx),
    .ry        (ry),
    .sc        (sc),
    .flag      (flag),
    .err       (err)
  );

  assign out_tdata = {sc, ry, rx};
  assign out_tuser = {err, flag};

endmodule

`default_nettype wire
